FILE: src/bped_pkg.sv
// Shared constants and types for the bandpass energy ping detector.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package bped_pkg;

  // Datapath sizing
  localparam int WINDOW_LEN     = 8;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 22;
  localparam int COEF_WIDTH     = 24;
  localparam int POWER_WIDTH    = 34;

  localparam int PROD_WIDTH  = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 3;
  localparam int SHIFT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;
  localparam int SQ_WIDTH    = 2 * SAMPLE_WIDTH;
  localparam int POS_WIDTH   = $clog2(WINDOW_LEN);

  // Configuration port sizing: 64-bit data, registers on 8-byte strides
  localparam int CFG_DATA_WIDTH = 64;
  localparam int CFG_ADDR_WIDTH = 6;
  localparam int CFG_IDX_LSB    = 3;
  localparam int CFG_IDX_WIDTH  = CFG_ADDR_WIDTH - CFG_IDX_LSB;

  typedef logic signed [SAMPLE_WIDTH-1:0] pcm_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic        [POWER_WIDTH-1:0]  power_t;

  // Register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_NUM_B0          = 3'd0,
    REG_NUM_B1          = 3'd1,
    REG_NUM_B2          = 3'd2,
    REG_DEN_A1          = 3'd3,
    REG_DEN_A2          = 3'd4,
    REG_POWER_THRESHOLD = 3'd5
  } reg_idx_t;

  // Reset values
  localparam coef_t  NUM_B0_RST    = 24'sd6852;
  localparam coef_t  NUM_B1_RST    = 24'sd0;
  localparam coef_t  NUM_B2_RST    = -24'sd6852;
  localparam coef_t  DEN_A1_RST    = -24'sd5921952;
  localparam coef_t  DEN_A2_RST    = 24'sd4180601;
  localparam power_t THRESHOLD_RST = 34'd107374;

endpackage

`default_nettype wire

FILE: src/bped_if.sv
// Valid/ready channel interfaces for samples in and window results out.
// Depends on bped_pkg.
`default_nettype none

interface bped_in_if import bped_pkg::*; ();
  logic valid;
  logic ready;
  pcm_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bped_out_if import bped_pkg::*; ();
  logic   valid;
  logic   ready;
  power_t window_power;
  logic   ping_detected;

  modport source (output valid, output window_power, output ping_detected, input ready);
  modport sink   (input valid, input window_power, input ping_detected, output ready);
endinterface

`default_nettype wire

FILE: src/bandpass_energy_ping_detector_top.sv
// Biquad bandpass filter, windowed energy sum and ping threshold, with APB setup port.
// Depends on bped_pkg and the channel interfaces in bped_if.sv.
`default_nettype none

// Accepts one signed 16-bit sample per cycle, unless stalled by a held result, and
// runs it through a direct-form-I biquad (Q2.22 coefficients, round half up,
// saturate to 16 bits). Filter outputs are squared and summed over non-overlapping
// windows of 8 samples; the 8th sample of each window yields one result request
// carrying the window power and a ping flag (power above threshold). Throughput is
// one sample per clock when not stalled, set by the feedback loop through the two
// feedback multipliers and the adder. A closing sample passes the filter
// register, then square/accumulate into the output register; a result held by the
// sink stalls only the closing sample of the next window. Filter state clears only
// on reset; coefficient writes should be made while the block is idle.
module bandpass_energy_ping_detector_top
  import bped_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  bped_in_if.sink                        in_ch,
  bped_out_if.source                     out_ch,

  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_pwdata,
  output logic      [CFG_DATA_WIDTH-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam logic signed [SHIFT_WIDTH-1:0] Y_MAX =
    {{(SHIFT_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SHIFT_WIDTH-1:0] Y_MIN = ~Y_MAX;
  localparam logic [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);

  // Configuration registers
  coef_t  num_b0_r, num_b1_r, num_b2_r, den_a1_r, den_a2_r;
  power_t threshold_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_WIDTH-1:CFG_IDX_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_b0_r    <= NUM_B0_RST;
      num_b1_r    <= NUM_B1_RST;
      num_b2_r    <= NUM_B2_RST;
      den_a1_r    <= DEN_A1_RST;
      den_a2_r    <= DEN_A2_RST;
      threshold_r <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_B0:          num_b0_r    <= cfg_pwdata[COEF_WIDTH-1:0];
        REG_NUM_B1:          num_b1_r    <= cfg_pwdata[COEF_WIDTH-1:0];
        REG_NUM_B2:          num_b2_r    <= cfg_pwdata[COEF_WIDTH-1:0];
        REG_DEN_A1:          den_a1_r    <= cfg_pwdata[COEF_WIDTH-1:0];
        REG_DEN_A2:          den_a2_r    <= cfg_pwdata[COEF_WIDTH-1:0];
        REG_POWER_THRESHOLD: threshold_r <= cfg_pwdata[POWER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_NUM_B0:          cfg_prdata = CFG_DATA_WIDTH'(num_b0_r);
      REG_NUM_B1:          cfg_prdata = CFG_DATA_WIDTH'(num_b1_r);
      REG_NUM_B2:          cfg_prdata = CFG_DATA_WIDTH'(num_b2_r);
      REG_DEN_A1:          cfg_prdata = CFG_DATA_WIDTH'(den_a1_r);
      REG_DEN_A2:          cfg_prdata = CFG_DATA_WIDTH'(den_a2_r);
      REG_POWER_THRESHOLD: cfg_prdata = CFG_DATA_WIDTH'(threshold_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Pipeline flow control: input reg (a), filter reg (b), output reg
  logic a_v_r, b_v_r, out_v_r;
  logic a_go, b_go, b_last, out_free;
  logic [POS_WIDTH-1:0] pos_r;

  assign b_last      = (pos_r == POS_WIDTH'(WINDOW_LEN - 1));
  assign out_free    = !out_v_r || out_ch.ready;
  assign b_go        = b_v_r && (!b_last || out_free);
  assign a_go        = a_v_r && (!b_v_r || b_go);
  assign in_ch.ready = !a_v_r || a_go;

  // Input register
  pcm_t x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      a_v_r <= 1'b1;
    end else if (a_go) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      x_r <= in_ch.sample;
    end
  end

  // Biquad: five products, sum, round half up, saturate
  pcm_t x1_r, x2_r, y1_r, y2_r, y_r;
  logic signed [PROD_WIDTH-1:0]  p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_WIDTH-1:0]   acc, acc_rnd;
  logic signed [SHIFT_WIDTH-1:0] y_shift;
  pcm_t                          y_new;

  always_comb begin
    p_b0    = num_b0_r * x_r;
    p_b1    = num_b1_r * x1_r;
    p_b2    = num_b2_r * x2_r;
    p_a1    = den_a1_r * y1_r;
    p_a2    = den_a2_r * y2_r;
    acc     = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
            - ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2);
    acc_rnd = acc + ROUND_HALF;
    y_shift = acc_rnd[ACC_WIDTH-1:COEF_FRAC_BITS];
    if (y_shift > Y_MAX) begin
      y_new = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_shift < Y_MIN) begin
      y_new = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_new = y_shift[SAMPLE_WIDTH-1:0];
    end
  end

  // Filter state and filter output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r  <= '0;
      x2_r  <= '0;
      y1_r  <= '0;
      y2_r  <= '0;
      b_v_r <= 1'b0;
    end else if (a_go) begin
      x1_r  <= x_r;
      x2_r  <= x1_r;
      y1_r  <= y_new;
      y2_r  <= y1_r;
      b_v_r <= 1'b1;
    end else if (b_go) begin
      b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      y_r <= y_new;
    end
  end

  // Square and saturating window accumulation
  logic [SQ_WIDTH-1:0]  sq;
  logic [POWER_WIDTH:0] sum;
  power_t               pacc_r, pacc_new;
  power_t               power_r;
  logic                 ping_r;

  always_comb begin
    sq       = SQ_WIDTH'(y_r * y_r);
    sum      = {1'b0, pacc_r} + (POWER_WIDTH+1)'(sq);
    pacc_new = sum[POWER_WIDTH] ? '1 : sum[POWER_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pacc_r <= '0;
      pos_r  <= '0;
    end else if (b_go) begin
      if (b_last) begin
        pacc_r <= '0;
        pos_r  <= '0;
      end else begin
        pacc_r <= pacc_new;
        pos_r  <= pos_r + POS_WIDTH'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (b_go && b_last) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_last) begin
      power_r <= pacc_new;
      ping_r  <= (pacc_new > threshold_r);
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.window_power  = power_r;
  assign out_ch.ping_detected = ping_r;

endmodule

`default_nettype wire

FILE: verif/bped_window_power_check.sv
// Scoreboard for the bandpass energy ping detector: tracks the setup writes,
// predicts each window result from accepted samples and compares it with the
// result channel. Depends on bped_pkg and the channel interfaces in bped_if.sv.

module bped_window_power_check
  import bped_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  bped_in_if                             in_mon,
  bped_out_if                            out_mon,

  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic                      cfg_pready,
  input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_pwdata,

  output int                             mismatch_count,
  output int                             windows_outstanding
);

  localparam longint Y_MAX      = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint Y_MIN      = -Y_MAX - 1;
  localparam longint POWER_CEIL = (longint'(1) <<< POWER_WIDTH) - 1;
  localparam longint HALF_LSB   = longint'(1) <<< (COEF_FRAC_BITS - 1);

  typedef struct packed {
    power_t power;
    logic   ping;
  } window_t;

  // Shadow copy of the setup registers
  coef_t  num_b0, num_b1, num_b2, den_a1, den_a2;
  power_t ping_level;

  // Filter history and window accumulation
  pcm_t   x_prev1, x_prev2, y_prev1, y_prev2;
  power_t energy;
  int     fill;

  window_t expected_windows[$];

  // One biquad step on the current history: exact sum, round half up, saturate
  function automatic pcm_t biquad_output(input pcm_t x);
    longint acc;
    acc = longint'(num_b0) * longint'(x)
        + longint'(num_b1) * longint'(x_prev1)
        + longint'(num_b2) * longint'(x_prev2)
        - longint'(den_a1) * longint'(y_prev1)
        - longint'(den_a2) * longint'(y_prev2);
    acc = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
    if (acc > Y_MAX) begin
      acc = Y_MAX;
    end else if (acc < Y_MIN) begin
      acc = Y_MIN;
    end
    return pcm_t'(acc);
  endfunction

  always @(posedge clk) begin
    pcm_t    y;
    longint  total;
    window_t want;
    if (!rst_n) begin
      num_b0         = NUM_B0_RST;
      num_b1         = NUM_B1_RST;
      num_b2         = NUM_B2_RST;
      den_a1         = DEN_A1_RST;
      den_a2         = DEN_A2_RST;
      ping_level     = THRESHOLD_RST;
      x_prev1        = '0;
      x_prev2        = '0;
      y_prev1        = '0;
      y_prev2        = '0;
      energy         = '0;
      fill           = 0;
      mismatch_count = 0;
      expected_windows.delete();
    end else begin
      // Register write on the access phase; unknown indexes are ignored
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[CFG_ADDR_WIDTH-1:CFG_IDX_LSB]))
          REG_NUM_B0:          num_b0     = coef_t'(cfg_pwdata[COEF_WIDTH-1:0]);
          REG_NUM_B1:          num_b1     = coef_t'(cfg_pwdata[COEF_WIDTH-1:0]);
          REG_NUM_B2:          num_b2     = coef_t'(cfg_pwdata[COEF_WIDTH-1:0]);
          REG_DEN_A1:          den_a1     = coef_t'(cfg_pwdata[COEF_WIDTH-1:0]);
          REG_DEN_A2:          den_a2     = coef_t'(cfg_pwdata[COEF_WIDTH-1:0]);
          REG_POWER_THRESHOLD: ping_level = cfg_pwdata[POWER_WIDTH-1:0];
          default: ;
        endcase
      end

      // Accepted sample: filter, square, accumulate; close the window on the last one
      if (in_mon.valid && in_mon.ready) begin
        y       = biquad_output(in_mon.sample);
        x_prev2 = x_prev1;
        x_prev1 = in_mon.sample;
        y_prev2 = y_prev1;
        y_prev1 = y;
        total   = longint'(energy) + longint'(y) * longint'(y);
        energy  = (total > POWER_CEIL) ? power_t'(POWER_CEIL) : power_t'(total);
        fill++;
        if (fill == WINDOW_LEN) begin
          expected_windows.push_back('{power: energy, ping: energy > ping_level});
          energy = '0;
          fill   = 0;
        end
      end

      // Accepted result: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: unexpected result request, expected none, got power %0d ping %0b",
                   $time, out_mon.window_power, out_mon.ping_detected);
          mismatch_count++;
        end else begin
          want = expected_windows.pop_front();
          if (out_mon.window_power !== want.power) begin
            $display("%0t: window_power expected %0d got %0d",
                     $time, want.power, out_mon.window_power);
            mismatch_count++;
          end
          if (out_mon.ping_detected !== want.ping) begin
            $display("%0t: ping_detected expected %0b got %0b (power %0d)",
                     $time, want.ping, out_mon.ping_detected, want.power);
            mismatch_count++;
          end
        end
      end
    end
    windows_outstanding = expected_windows.size();
  end

endmodule

FILE: verif/bandpass_energy_ping_detector_top_tb.sv
// Top of the ping detector testbench: clock, reset, sample and setup stimulus,
// result-side backpressure and the verdict. Depends on bped_pkg, bped_if.sv,
// the detector top level and bped_window_power_check.

module bandpass_energy_ping_detector_top_tb;
  import bped_pkg::*;

  localparam int     IDLE_PCT     = 8;
  localparam int     PHASES       = 8;
  localparam int     PHASE_ITEMS  = 125;
  localparam int     CALM_PHASE   = 3;
  localparam int     PIPE_SLACK   = 8;
  localparam int     TIMEOUT      = 400000;
  localparam coef_t  COEF_MAX     = 24'sh7FFFFF;
  localparam coef_t  COEF_MIN     = 24'sh800000;
  localparam power_t POWER_ALL1   = '1;
  localparam power_t POWER_TOP    = power_t'(1) << (POWER_WIDTH - 1);

  typedef enum int {
    STYLE_DEFAULT,
    STYLE_FULL,
    STYLE_GENTLE,
    STYLE_EXTREME
  } coef_style_t;

  logic clk;
  logic rst_n;
  logic calm;

  bped_in_if  in_ch();
  bped_out_if out_ch();

  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [CFG_ADDR_WIDTH-1:0] cfg_paddr;
  logic [CFG_DATA_WIDTH-1:0] cfg_pwdata;
  logic [CFG_DATA_WIDTH-1:0] cfg_prdata;
  logic                      cfg_pready;

  int mismatch_count;
  int windows_outstanding;

  bandpass_energy_ping_detector_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bped_window_power_check power_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_pready          (cfg_pready),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .mismatch_count      (mismatch_count),
    .windows_outstanding (windows_outstanding)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result-side backpressure, none during the calm phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Hard stop
  initial begin
    #(TIMEOUT);
    $display("** bandpass_energy_ping_detector_top: FAILED **");
    $finish;
  end

  // Mostly full-scale noise, some rail values and some low-level signal
  function automatic pcm_t draw_sample();
    case ($urandom_range(19))
      0, 1:    return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
      2:       return 16'sh8000 + pcm_t'($urandom_range(3));
      3, 4, 5: return pcm_t'(int'($urandom_range(512)) - 256);
      default: return pcm_t'($urandom);
    endcase
  endfunction

  function automatic coef_t draw_coef(input coef_style_t style, input coef_t rst_val);
    case (style)
      STYLE_FULL:   return coef_t'($urandom);
      // feedback kept within +-0.25 so the filter stays stable
      STYLE_GENTLE: return coef_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      STYLE_EXTREME: begin
        case ($urandom_range(4))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return '0;
          3:       return '1;
          default: return coef_t'(1);
        endcase
      end
      default:      return rst_val;
    endcase
  endfunction

  function automatic power_t draw_threshold();
    case ($urandom_range(4))
      0:       return '0;
      1:       return POWER_ALL1;
      2:       return POWER_TOP;
      3:       return power_t'($urandom_range(1 << 24));
      default: return {2'($urandom_range(3)), 32'($urandom)};
    endcase
  endfunction

  task automatic push_sample(input pcm_t s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending, wait for every predicted window, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (windows_outstanding != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Writes all registers plus the two unused indexes; junk in the unused data bits
  task automatic program_regs(input coef_t b0, b1, b2, a1, a2, input power_t level);
    logic [CFG_DATA_WIDTH-1:0] vals [8];
    for (int i = 0; i < 8; i++) vals[i] = {$urandom, $urandom};
    vals[REG_NUM_B0][COEF_WIDTH-1:0]           = b0;
    vals[REG_NUM_B1][COEF_WIDTH-1:0]           = b1;
    vals[REG_NUM_B2][COEF_WIDTH-1:0]           = b2;
    vals[REG_DEN_A1][COEF_WIDTH-1:0]           = a1;
    vals[REG_DEN_A2][COEF_WIDTH-1:0]           = a2;
    vals[REG_POWER_THRESHOLD][POWER_WIDTH-1:0] = level;
    for (int i = 0; i < 8; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= CFG_ADDR_WIDTH'(i << CFG_IDX_LSB);
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    pcm_t        corner_samples [8];
    coef_style_t style;
    corner_samples = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                       16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5A5A};
    rst_n        = 1'b0;
    calm         = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients with rail-to-rail and near-zero samples
    foreach (corner_samples[i]) push_sample(corner_samples[i]);
    settle();

    // Unstable filter driven to the negative rail, ping on any power
    program_regs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, '0);
    repeat (WINDOW_LEN) push_sample(16'sh8000);
    settle();

    // Filter muted: zero power never exceeds a threshold
    program_regs('0, '0, '0, '0, '0, POWER_ALL1);
    repeat (WINDOW_LEN) push_sample(draw_sample());
    settle();

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      style = coef_style_t'(p % 4);
      program_regs(draw_coef(style, NUM_B0_RST), draw_coef(style, NUM_B1_RST),
                   draw_coef(style, NUM_B2_RST),
                   (style == STYLE_GENTLE) ? coef_t'(int'($urandom_range(1 << 21)) - (1 << 20))
                                           : draw_coef(style, DEN_A1_RST),
                   (style == STYLE_GENTLE) ? coef_t'(int'($urandom_range(1 << 21)) - (1 << 20))
                                           : draw_coef(style, DEN_A2_RST),
                   draw_threshold());
      calm = (p == CALM_PHASE);
      repeat (PHASE_ITEMS) push_sample(draw_sample());
      settle();
      calm = 1'b0;
    end

    if (mismatch_count == 0 && windows_outstanding == 0) begin
      $display("** bandpass_energy_ping_detector_top: PASSED **");
    end else begin
      $display("** bandpass_energy_ping_detector_top: FAILED **");
    end
    $finish;
  end

endmodule
